>>> hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// Tensor permute scatter package
// Shared widths, codes, transaction payloads and control structs.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int MAX_AXES     = 6;
   localparam int MAX_ELEMENTS = 4096;
   localparam int ADDR_W       = 12;
   localparam int AXIS_W       = 3;
   localparam int SIZE_W       = 8;
   localparam int COUNT_W      = 13;
   localparam int DATA_W       = 32;
   localparam int PROD_W       = 64;
   localparam int ACC_W        = 66;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 6;
   localparam int SIZES_W      = 48;
   localparam int ORDER_W      = 18;

   typedef enum logic [1:0] {
      REQ_PRELOAD = 2'd0,
      REQ_SOURCE  = 2'd1,
      REQ_READ    = 2'd2,
      REQ_UNUSED  = 2'd3
   } tps_req_kind_type;

   typedef enum logic [2:0] {
      REG_DIMS      = 3'd0,
      REG_SIZES     = 3'd1,
      REG_ORDER     = 3'd2,
      REG_COUNT     = 3'd3,
      REG_SCALE_NEW = 3'd4,
      REG_SCALE_OLD = 3'd5
   } tps_reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRELOAD,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_ADDR,
      ST_FETCH,
      ST_FETCH_DATA,
      ST_SCALE,
      ST_RESP
   } tps_state_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_MUL_NEW,
      SC_MUL_OLD,
      SC_SUM
   } tps_scale_phase_type;

   typedef struct packed {
      tps_req_kind_type           req_type;
      logic [ADDR_W-1:0]          entry_index;
      logic signed [DATA_W-1:0]   data_value;
   } tps_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]          dest_index;
      logic signed [DATA_W-1:0]   dest_value;
      logic                       last_element;
   } tps_rsp_type;

   typedef struct packed {
      logic [AXIS_W-1:0]                     dims;
      logic [MAX_AXES-1:0][SIZE_W-1:0]       sizes;
      logic [MAX_AXES-1:0][AXIS_W-1:0]       order;
      logic [COUNT_W-1:0]                    count;
   } tps_geom_type;

   typedef struct packed {
      logic start;
      logic step;
   } tps_addr_ctrl_type;

   typedef struct packed {
      logic              done;
      logic              last;
      logic [ADDR_W-1:0] addr;
   } tps_addr_stat_type;

endpackage

>>> hw/rtl/tps_addr_unit.sv
// ----------------------------------------------------------------------------
// Destination address unit
// Source digit counter and a shared multiplier that walks the permuted
// positions to form the destination address.
// ----------------------------------------------------------------------------
module tps_addr_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  tps_pkg::tps_geom_type     geom,
   input  tps_pkg::tps_addr_ctrl_type ctrl,
   output tps_pkg::tps_addr_stat_type stat
);
   import tps_pkg::*;

   logic [MAX_AXES-1:0][SIZE_W-1:0] digit_ff, digit_in;
   logic [ADDR_W-1:0]               pos_ff, pos_in;
   logic [ADDR_W-1:0]               before_ff, before_in;
   logic [ADDR_W-1:0]               acc_ff, acc_in;
   logic [AXIS_W-1:0]               slot_ff, slot_in;
   logic [MAX_AXES-1:0]             seen_ff, seen_in;
   logic                            phase_ff, phase_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [AXIS_W-1:0]               axis;
   logic                            axis_ok;
   logic [SIZE_W-1:0]               mul_a;
   logic [ADDR_W+SIZE_W-1:0]        product;
   logic                            last;

   assign axis    = geom.order[slot_ff];
   assign axis_ok = axis < geom.dims;
   assign mul_a   = phase_ff ? (axis_ok ? geom.sizes[axis] : SIZE_W'(1))
                             : (axis_ok ? digit_ff[axis] : '0);
   assign product = mul_a * before_ff;
   assign last    = ({1'b0, pos_ff} + COUNT_W'(1)) >= geom.count;

   always_comb begin
      logic carry;
      carry     = 1'b1;
      digit_in  = digit_ff;
      pos_in    = pos_ff;
      before_in = before_ff;
      acc_in    = acc_ff;
      slot_in   = slot_ff;
      seen_in   = seen_ff;
      phase_in  = phase_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctrl.start) begin
         slot_in   = geom.dims - AXIS_W'(1);
         before_in = ADDR_W'(1);
         acc_in    = '0;
         seen_in   = '0;
         phase_in  = 1'b0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            if (axis_ok && !seen_ff[axis]) begin
               acc_in        = acc_ff + product[ADDR_W-1:0];
               seen_in[axis] = 1'b1;
            end
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            if (slot_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               before_in = product[ADDR_W-1:0];
               slot_in   = slot_ff - AXIS_W'(1);
            end
         end
      end
      if (ctrl.step) begin
         if (last) begin
            pos_in   = '0;
            digit_in = '0;
         end else begin
            pos_in = pos_ff + ADDR_W'(1);
            for (int k = MAX_AXES - 1; k >= 0; k--) begin
               if (AXIS_W'(k) < geom.dims && carry) begin
                  if (({1'b0, digit_ff[k]} + 9'd1) >= {1'b0, geom.sizes[k]}) begin
                     digit_in[k] = '0;
                  end else begin
                     digit_in[k] = digit_ff[k] + SIZE_W'(1);
                     carry       = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
         pos_ff   <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         digit_ff <= digit_in;
         pos_ff   <= pos_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      before_ff <= before_in;
      acc_ff    <= acc_in;
      slot_ff   <= slot_in;
      seen_ff   <= seen_in;
   end

   assign stat.done = done_ff;
   assign stat.last = last;
   assign stat.addr = acc_ff;

endmodule

>>> hw/rtl/tps_scale_unit.sv
// ----------------------------------------------------------------------------
// Scale and accumulate unit
// One 32x32 signed multiplier used for alpha*a then beta*old; rounds the
// Q32.32 sum to Q16.16 and saturates.
// ----------------------------------------------------------------------------
module tps_scale_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               use_old,
   input  logic signed [tps_pkg::DATA_W-1:0]  alpha,
   input  logic signed [tps_pkg::DATA_W-1:0]  beta,
   input  logic signed [tps_pkg::DATA_W-1:0]  a_value,
   input  logic signed [tps_pkg::DATA_W-1:0]  old_value,
   output logic                               done,
   output logic signed [tps_pkg::DATA_W-1:0]  result
);
   import tps_pkg::*;

   tps_scale_phase_type       phase_ff, phase_in;
   logic signed [DATA_W-1:0]  a_ff, old_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      done_ff, done_in;
   logic signed [DATA_W-1:0]  mul_x, mul_y;
   logic signed [PROD_W-1:0]  product;
   logic signed [ACC_W-17:0]  shifted;

   assign mul_x   = (phase_ff == SC_MUL_NEW) ? alpha : beta;
   assign mul_y   = (phase_ff == SC_MUL_NEW) ? a_ff : old_ff;
   assign product = mul_x * mul_y;

   always_comb begin
      phase_in = phase_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         SC_IDLE: begin
            if (start) begin
               phase_in = SC_MUL_NEW;
            end
         end
         SC_MUL_NEW: begin
            prod_in  = product;
            phase_in = SC_MUL_OLD;
         end
         SC_MUL_OLD: begin
            acc_in   = ACC_W'(prod_ff) + ACC_W'(32'sh8000);
            prod_in  = use_old ? product : '0;
            phase_in = SC_SUM;
         end
         SC_SUM: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            done_in  = 1'b1;
            phase_in = SC_IDLE;
         end
         default: phase_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      if (start) begin
         a_ff   <= a_value;
         old_ff <= old_value;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign shifted = acc_ff[ACC_W-1:16];

   always_comb begin
      if (shifted > (ACC_W-16)'(32'sh7FFFFFFF)) begin
         result = 32'sh7FFFFFFF;
      end else if (shifted < -(ACC_W-16)'(64'sh80000000)) begin
         result = 32'sh80000000;
      end else begin
         result = shifted[DATA_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

>>> hw/rtl/tensor_permute_scatter_unit.sv
// ----------------------------------------------------------------------------
// Tensor permute scatter unit
// Axis-permuting transpose with scale and accumulate into a destination store.
// ----------------------------------------------------------------------------
// Preload writes the store, then answers; read fetches from the store, then answers.
// A source element waits for the address unit, which walks each axis position,
// and for the scale unit, whose shared multiplier takes two products.
// One transaction at a time; the next is taken once the result is registered.
// Synchronous reset clears control state, digits and configuration; the
// destination store is not cleared and needs no clearing pass.
module tensor_permute_scatter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tps_pkg::tps_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tps_pkg::tps_rsp_type               rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tps_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tps_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tps_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import tps_pkg::*;

   logic [AXIS_W-1:0]         dims_ff;
   logic [SIZES_W-1:0]        sizes_ff;
   logic [ORDER_W-1:0]        order_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic signed [DATA_W-1:0]  scale_new_ff;
   logic signed [DATA_W-1:0]  scale_old_ff;
   tps_reg_index_type         reg_index;
   logic                      csr_write;

   tps_geom_type              geom;
   tps_addr_ctrl_type         addr_ctrl;
   tps_addr_stat_type         addr_stat;

   tps_state_type             state_ff, state_in;
   tps_req_type               req_ff;
   tps_rsp_type               res_ff, res_in;
   tps_rsp_type               rsp_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_load;

   logic [DATA_W-1:0]         mem [MAX_ELEMENTS];
   logic [DATA_W-1:0]         rdata_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [DATA_W-1:0]         mem_wdata;

   logic                      scale_start;
   logic                      scale_done;
   logic signed [DATA_W-1:0]  scale_result;

   assign pready    = 1'b1;
   assign reg_index = tps_reg_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= AXIS_W'(1);
         sizes_ff     <= 48'h0101_0101_0101;
         order_ff     <= 18'o543210;
         count_ff     <= COUNT_W'(1);
         scale_new_ff <= 32'sh0001_0000;
         scale_old_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_DIMS:      dims_ff      <= pwdata[AXIS_W-1:0];
            REG_SIZES:     sizes_ff     <= pwdata[SIZES_W-1:0];
            REG_ORDER:     order_ff     <= pwdata[ORDER_W-1:0];
            REG_COUNT:     count_ff     <= pwdata[COUNT_W-1:0];
            REG_SCALE_NEW: scale_new_ff <= pwdata[DATA_W-1:0];
            REG_SCALE_OLD: scale_old_ff <= pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DIMS:      prdata = CSR_DATA_W'(dims_ff);
         REG_SIZES:     prdata = CSR_DATA_W'(sizes_ff);
         REG_ORDER:     prdata = CSR_DATA_W'(order_ff);
         REG_COUNT:     prdata = CSR_DATA_W'(count_ff);
         REG_SCALE_NEW: prdata = CSR_DATA_W'(unsigned'(scale_new_ff));
         REG_SCALE_OLD: prdata = CSR_DATA_W'(unsigned'(scale_old_ff));
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      if (dims_ff == '0) begin
         geom.dims = AXIS_W'(1);
      end else if (dims_ff > AXIS_W'(MAX_AXES)) begin
         geom.dims = AXIS_W'(MAX_AXES);
      end else begin
         geom.dims = dims_ff;
      end
      for (int k = 0; k < MAX_AXES; k++) begin
         geom.sizes[k] = (sizes_ff[k*SIZE_W +: SIZE_W] == '0) ? SIZE_W'(1)
                                                          : sizes_ff[k*SIZE_W +: SIZE_W];
         geom.order[k] = order_ff[k*AXIS_W +: AXIS_W];
      end
      if (count_ff == '0) begin
         geom.count = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_ELEMENTS)) begin
         geom.count = COUNT_W'(MAX_ELEMENTS);
      end else begin
         geom.count = count_ff;
      end
   end

   tps_addr_unit u_addr (
      .clock (clock),
      .reset (reset),
      .geom  (geom),
      .ctrl  (addr_ctrl),
      .stat  (addr_stat)
   );

   tps_scale_unit u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (scale_start),
      .use_old   (scale_old_ff != '0),
      .alpha     (scale_new_ff),
      .beta      (scale_old_ff),
      .a_value   (req_ff.data_value),
      .old_value (rdata_ff),
      .done      (scale_done),
      .result    (scale_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_addr   = (state_ff == ST_RD_ISSUE) ? req_ff.entry_index : addr_stat.addr;

   always_comb begin
      state_in       = state_ff;
      res_in         = res_ff;
      addr_ctrl      = '0;
      scale_start    = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = addr_stat.addr;
      mem_wdata      = scale_result;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.req_type)
                  REQ_PRELOAD: state_in = ST_PRELOAD;
                  REQ_READ:    state_in = ST_RD_ISSUE;
                  REQ_SOURCE: begin
                     addr_ctrl.start = 1'b1;
                     state_in        = ST_ADDR;
                  end
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_PRELOAD: begin
            mem_we    = 1'b1;
            mem_waddr = req_ff.entry_index;
            mem_wdata = req_ff.data_value;
            res_in    = '{dest_index: req_ff.entry_index, dest_value: req_ff.data_value,
                          last_element: 1'b0};
            state_in  = ST_RESP;
         end
         ST_RD_ISSUE: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            res_in   = '{dest_index: req_ff.entry_index, dest_value: rdata_ff,
                         last_element: 1'b0};
            state_in = ST_RESP;
         end
         ST_ADDR: begin
            if (addr_stat.done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_FETCH_DATA;
         ST_FETCH_DATA: begin
            scale_start = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_done) begin
               mem_we         = 1'b1;
               res_in         = '{dest_index: addr_stat.addr, dest_value: scale_result,
                                  last_element: addr_stat.last};
               addr_ctrl.step = 1'b1;
               state_in       = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/tps_checker.sv
// ----------------------------------------------------------------------------
// Tensor permute scatter port checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
module tps_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  tps_pkg::tps_req_type  req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tps_pkg::tps_rsp_type  rsp_data
);
   import tps_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.req_type != REQ_UNUSED |=> !req_ready)
      else $error("second transaction taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a transaction in flight");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the channels");

endmodule

bind tensor_permute_scatter_unit tps_checker u_tps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> test/tensor_permute_scatter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute scatter checker
// Watches the request, result and register ports, keeps its own copy of the
// geometry, digit counter and destination store, predicts every result and
// compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module tensor_permute_scatter_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  tps_pkg::tps_req_type           req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  tps_pkg::tps_rsp_type           rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [tps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tps_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             fail_count,
   output int                             pending_count,
   output int                             result_count,
   output int                             last_count
);
   import tps_pkg::*;

   logic [DATA_W-1:0]  dest_mem [MAX_ELEMENTS];
   logic [7:0]         digit [MAX_AXES];
   int unsigned        position;
   logic [2:0]         dims_reg;
   logic [SIZES_W-1:0] sizes_reg;
   logic [ORDER_W-1:0] order_reg;
   logic [COUNT_W-1:0] count_reg;
   logic [31:0]        alpha_reg;
   logic [31:0]        beta_reg;
   tps_rsp_type        expected_q[$];

   function automatic int unsigned dims_eff();
      int unsigned d;
      d = dims_reg;
      if (d == 0) d = 1;
      if (d > MAX_AXES) d = MAX_AXES;
      return d;
   endfunction

   function automatic int unsigned size_eff(int unsigned k);
      int unsigned s;
      s = sizes_reg[8*k +: 8];
      return (s == 0) ? 1 : s;
   endfunction

   function automatic int unsigned count_eff();
      int unsigned n;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
      return n;
   endfunction

   function automatic logic [ADDR_W-1:0] permuted_address();
      longint unsigned run [MAX_AXES];
      longint unsigned stride [MAX_AXES];
      longint unsigned sum;
      int unsigned d, p;
      d = dims_eff();
      sum = 0;
      run[d-1] = 1;
      for (int i = d - 1; i >= 1; i--) begin
         p = order_reg[3*i +: 3];
         run[i-1] = run[i] * ((p < d) ? size_eff(p) : 1);
      end
      for (int i = 0; i < MAX_AXES; i++) stride[i] = 0;
      for (int i = 0; i < d; i++) begin
         p = order_reg[3*i +: 3];
         if (p < d) stride[p] = run[i];
      end
      for (int i = 0; i < d; i++) sum += digit[i] * stride[i];
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [31:0] scaled_sum(logic signed [31:0] a,
                                              logic signed [31:0] old,
                                              bit with_old);
      logic signed [65:0] total;
      logic signed [65:0] r;
      total = 66'(signed'(alpha_reg)) * 66'(a);
      if (with_old) total += 66'(signed'(beta_reg)) * 66'(old);
      r = (total + 66'sh8000) >>> 16;
      if (r > 66'sd2147483647) r = 66'sd2147483647;
      if (r < -66'sd2147483648) r = -66'sd2147483648;
      return r[31:0];
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      tps_rsp_type exp_rsp;
      tps_rsp_type got;
      logic [ADDR_W-1:0] a;
      int unsigned k;
      if (reset) begin
         position = 0;
         for (int i = 0; i < MAX_AXES; i++) digit[i] = 0;
         dims_reg = 1;
         sizes_reg = 48'd1103823438081;
         order_reg = 18'd181896;
         count_reg = 1;
         alpha_reg = 32'd65536;
         beta_reg = 0;
         expected_q.delete();
         fail_count = 0;
         result_count = 0;
         last_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr >> 3)
               REG_DIMS:      dims_reg = pwdata[2:0];
               REG_SIZES:     sizes_reg = pwdata[SIZES_W-1:0];
               REG_ORDER:     order_reg = pwdata[ORDER_W-1:0];
               REG_COUNT:     count_reg = pwdata[COUNT_W-1:0];
               REG_SCALE_NEW: alpha_reg = pwdata[31:0];
               REG_SCALE_OLD: beta_reg = pwdata[31:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            result_count++;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", got, 0);
            end else begin
               exp_rsp = expected_q.pop_front();
               if (got.dest_index !== exp_rsp.dest_index)
                  report_mismatch("dest_index", got.dest_index, exp_rsp.dest_index);
               if (got.dest_value !== exp_rsp.dest_value)
                  report_mismatch("dest_value", got.dest_value, exp_rsp.dest_value);
               if (got.last_element !== exp_rsp.last_element)
                  report_mismatch("last_element", got.last_element, exp_rsp.last_element);
               if (got.last_element === 1'b1) last_count++;
            end
         end
         if (req_valid && req_ready) begin
            exp_rsp = '0;
            case (req_data.req_type)
               REQ_PRELOAD: begin
                  dest_mem[req_data.entry_index] = req_data.data_value;
                  exp_rsp.dest_index = req_data.entry_index;
                  exp_rsp.dest_value = req_data.data_value;
                  expected_q.push_back(exp_rsp);
               end
               REQ_READ: begin
                  exp_rsp.dest_index = req_data.entry_index;
                  exp_rsp.dest_value = dest_mem[req_data.entry_index];
                  expected_q.push_back(exp_rsp);
               end
               REQ_SOURCE: begin
                  a = permuted_address();
                  exp_rsp.dest_index = a;
                  exp_rsp.dest_value = scaled_sum(req_data.data_value, dest_mem[a],
                                                  beta_reg != 0);
                  dest_mem[a] = exp_rsp.dest_value;
                  if (position + 1 >= count_eff()) begin
                     exp_rsp.last_element = 1'b1;
                     position = 0;
                     for (int i = 0; i < MAX_AXES; i++) digit[i] = 0;
                  end else begin
                     position++;
                     k = dims_eff();
                     while (k > 0) begin
                        k--;
                        if (digit[k] + 1 >= size_eff(k)) digit[k] = 0;
                        else begin
                           digit[k]++;
                           break;
                        end
                     end
                  end
                  expected_q.push_back(exp_rsp);
               end
               default: ;
            endcase
         end
      end
      pending_count = expected_q.size();
   end
endmodule

>>> test/tensor_permute_scatter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute scatter unit testbench
// Drives preload, source and read transactions across a range of tensor
// geometries and scales, with random idling on both channels; a checker
// beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tensor_permute_scatter_unit_tb;
   import tps_pkg::*;

   localparam longint CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tps_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tps_rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   int fail_count, pending_count, result_count, last_count;
   longint cycle_count = 0;
   bit quiet_phase = 0;
   int item_count = 0;
   int tensor_count = 0;
   int geom_size [MAX_AXES];
   int geom_dims;
   int geom_total;
   bit written [MAX_ELEMENTS];

   tensor_permute_scatter_unit dut (.*);

   tensor_permute_scatter_checker checker_inst (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tensor_permute_scatter_unit regression: fail");
         $finish;
      end
   end

   // receiver stall bursts
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_register(tps_reg_index_type idx, logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_ADDR_W'(idx) << 3;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // valid stays high into the next transaction; idle gaps and drain drop it
   task automatic send(tps_req_kind_type kind, logic [11:0] idx, logic [31:0] value);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      if (kind == REQ_SOURCE) written[checker_inst.permuted_address()] = 1'b1;
      req_data <= '{req_type: kind, entry_index: idx, data_value: value};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (kind == REQ_PRELOAD) written[idx] = 1'b1;
      if (kind != REQ_UNUSED) item_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 131072) - 65536;
         default: return $urandom;
      endcase
   endfunction

   // pick sizes with a small product, a random permutation, and program all
   task automatic program_geometry(int dims, bit with_old, bit extreme_scale);
      logic [47:0] sizes;
      logic [17:0] order;
      int perm [MAX_AXES];
      int j, t;
      sizes = '0;
      order = '0;
      geom_total = 1;
      geom_dims = dims;
      for (int k = 0; k < dims; k++) begin
         geom_size[k] = (geom_total < 64) ? $urandom_range(1, 4) : 1;
         geom_total *= geom_size[k];
         sizes[8*k +: 8] = geom_size[k];
         perm[k] = k;
      end
      for (int k = dims - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = perm[k]; perm[k] = perm[j]; perm[j] = t;
      end
      for (int k = 0; k < dims; k++) order[3*k +: 3] = perm[k];
      write_register(REG_DIMS, dims);
      write_register(REG_SIZES, sizes);
      write_register(REG_ORDER, order);
      write_register(REG_COUNT, geom_total);
      write_register(REG_SCALE_NEW, extreme_scale ? random_value() :
                     32'($urandom_range(0, 262144)) - 32'd131072);
      write_register(REG_SCALE_OLD, with_old ? (extreme_scale ? random_value() :
                     32'($urandom_range(1, 131072))) : 32'd0);
   endtask

   // one tensor; with accumulate, cover the whole destination range first
   task automatic run_tensor(bit with_old);
      int r;
      if (with_old)
         for (int a = 0; a < geom_total; a++)
            if (!written[a]) send(REQ_PRELOAD, a, random_value());
      for (int e = 0; e < geom_total; e++) begin
         if ($urandom_range(0, 9) == 0) send(REQ_UNUSED, $urandom, $urandom);
         r = $urandom_range(0, geom_total - 1);
         if (written[r] && $urandom_range(0, 9) == 0) send(REQ_READ, r, 0);
         send(REQ_SOURCE, $urandom, random_value());
         if (written[$urandom_range(0, geom_total - 1)] && $urandom_range(0, 7) == 0)
            send(REQ_PRELOAD, $urandom_range(0, geom_total - 1), random_value());
      end
      tensor_count++;
   endtask

   initial begin
      logic [11:0] probe;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of preload and read, default one-element tensor
      send(REQ_PRELOAD, 12'hFFF, 32'h7FFF_FFFF);
      send(REQ_PRELOAD, 12'h000, 32'h8000_0000);
      send(REQ_PRELOAD, 12'h555, 32'hAAAA_AAAA);
      send(REQ_READ, 12'hFFF, 0);
      send(REQ_READ, 12'h000, 0);
      send(REQ_READ, 12'h555, 0);
      send(REQ_UNUSED, 12'hABC, 32'h1234_5678);
      send(REQ_SOURCE, 12'hFFF, 32'h7FFF_FFFF);
      drain();
      // out-of-range dims, zero sizes, bad and repeated order, big count
      write_register(REG_DIMS, 0);
      write_register(REG_COUNT, 0);
      write_register(REG_SCALE_NEW, 32'h7FFF_FFFF);
      write_register(REG_SCALE_OLD, 32'h8000_0000);
      send(REQ_SOURCE, 0, 32'h7FFF_FFFF);
      send(REQ_SOURCE, 0, 32'h8000_0000);
      drain();
      write_register(REG_DIMS, 7);
      write_register(REG_SIZES, 48'h0003_0002_0004);
      write_register(REG_ORDER, 18'o770510);
      write_register(REG_COUNT, 13'h1FFF);
      write_register(REG_SCALE_OLD, 0);
      write_register(REG_SCALE_NEW, 32'h8000_0000);
      for (int e = 0; e < 8; e++) send(REQ_SOURCE, 0, $urandom);
      drain();
      write_register(REG_SIZES, 48'hFFFF_FFFF_FFFF);
      write_register(REG_ORDER, 18'o000000);
      write_register(REG_COUNT, 13'd4096);
      write_register(REG_SCALE_NEW, 32'h0001_0000);
      for (int e = 0; e < 3; e++) send(REQ_SOURCE, 0, $urandom);
      drain();
      // realign digit counter with a fresh one-element tensor
      write_register(REG_COUNT, 1);
      send(REQ_SOURCE, 0, 1);
      drain();

      // random: well-formed tensors, some with accumulate
      while (item_count < 1500) begin
         if (item_count > 1250) quiet_phase = 1;
         program_geometry($urandom_range(1, MAX_AXES), $urandom_range(0, 1),
                          $urandom_range(0, 3) == 0);
         run_tensor(checker_inst.beta_reg != 0);
         drain();
         probe = $urandom;
         if (written[probe]) begin
            send(REQ_READ, probe, 0);
            drain();
         end
      end
      drain();
      repeat (50) @(negedge clock);

      $display("covered %0d transactions, %0d results, %0d tensors completed",
               item_count, result_count, last_count);
      $display("geometries of 1 to %0d axes, with and without accumulate", MAX_AXES);
      if (fail_count == 0 && pending_count == 0)
         $display("tensor_permute_scatter_unit regression: pass");
      else
         $display("tensor_permute_scatter_unit regression: fail");
      $finish;
   end
endmodule
